>>> rtl/cldr_pkg.sv
// Shared types and constants of the clipped line and rectangle outline drawer.
package cldr_pkg;

  localparam int CMD_BITS       = 2;
  localparam int RECT_DIM_BITS  = 11;
  localparam int SCREEN_BITS    = 11;
  localparam int CFG_INDEX_BITS = 1;
  localparam int COLOR_BITS     = 16;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LINE = 2'd0,
    CMD_RECT = 2'd1,
    CMD_STEP = 2'd2
  } cmd_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_VIEW_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VIEW_HEIGHT = 1'd1;

  localparam logic [SCREEN_BITS-1:0] VIEW_WIDTH_RESET  = 11'd320;
  localparam logic [SCREEN_BITS-1:0] VIEW_HEIGHT_RESET = 11'd240;

endpackage

>>> rtl/cldr_if.sv
// Request channel interfaces: drawing commands in, pixels out.
interface cldr_cmd_if #(
  parameter int COORD_BITS = 12
);
  logic                                   valid;
  logic                                   ready;
  logic [cldr_pkg::CMD_BITS-1:0]          command;
  logic signed [COORD_BITS-1:0]           x_start;
  logic signed [COORD_BITS-1:0]           y_start;
  logic signed [COORD_BITS-1:0]           x_end;
  logic signed [COORD_BITS-1:0]           y_end;
  logic [cldr_pkg::RECT_DIM_BITS-1:0]     rect_width;
  logic [cldr_pkg::RECT_DIM_BITS-1:0]     rect_height;
  logic [cldr_pkg::COLOR_BITS-1:0]        color;

  modport source (
    output valid, command, x_start, y_start, x_end, y_end, rect_width, rect_height, color,
    input  ready
  );
  modport sink (
    input  valid, command, x_start, y_start, x_end, y_end, rect_width, rect_height, color,
    output ready
  );
endinterface

interface cldr_pixel_if #(
  parameter int COORD_BITS      = 12,
  parameter int SCREEN_DIM_BITS = 10
);
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS:0]        pixel_x;
  logic signed [COORD_BITS:0]        pixel_y;
  logic [2*SCREEN_DIM_BITS-1:0]      pixel_address;
  logic                              visible;
  logic [cldr_pkg::COLOR_BITS-1:0]   pixel_color;
  logic                              last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_address, visible, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_address, visible, pixel_color, last_pixel,
    output ready
  );
endinterface

>>> rtl/clipped_line_rect_outline_drawer.sv
// Top level of the line and rectangle outline pixel generator.
//
//   channel  dir  handshake        carries
//   cmd      in   valid / ready    command, endpoints, rectangle size, colour
//   pix      out  valid / ready    pixel position, address, visible, colour, last
//   cfg      in   cfg_write        screen width and height
//
// The walker state advances on the edge that accepts a step request, and the pixel
// lands in the output register on that same edge.
// The path is set by the row-times-width multiply and the Bresenham error update.
// Reset is synchronous; the drawer comes up idle with a 320 by 240 screen.
// cmd.ready is low only while a pixel sits in the output register and pix.ready
// is low, so a stalled sink holds one pixel and the next request waits.
module clipped_line_rect_outline_drawer #(
  parameter int COORD_BITS      = 12,
  parameter int SCREEN_DIM_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [cldr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [cldr_pkg::SCREEN_BITS-1:0]      cfg_data,
  cldr_cmd_if.sink                              cmd,
  cldr_pixel_if.source                          pix
);
  import cldr_pkg::*;

  // Rectangle corners reach origin plus width, so keep headroom for that.
  localparam int CW  = (COORD_BITS >= RECT_DIM_BITS + 1) ? COORD_BITS + 1 : RECT_DIM_BITS + 2;
  localparam int EW  = CW + 2;
  localparam int EW1 = EW + 1;
  localparam int PW  = COORD_BITS + 1;
  localparam int AW  = 2 * SCREEN_DIM_BITS;

  logic [SCREEN_BITS-1:0] view_width;
  logic [SCREEN_BITS-1:0] view_height;

  logic                 active, active_next;
  logic                 is_rectangle, is_rectangle_next;
  logic [1:0]           segment_index, segment_index_next;
  logic signed [CW-1:0] cur_x, cur_x_next, cur_y, cur_y_next;
  logic signed [CW-1:0] target_x, target_x_next, target_y, target_y_next;
  logic [CW-1:0]        delta_x, delta_x_next, delta_y, delta_y_next;
  logic                 step_x_neg, step_x_neg_next, step_y_neg, step_y_neg_next;
  logic signed [EW-1:0] error_term, error_term_next;
  logic [COLOR_BITS-1:0] draw_color, draw_color_next;
  logic signed [CW-1:0] corner_l, corner_t, corner_r, corner_b;
  logic signed [CW-1:0] corner_l_next, corner_t_next, corner_r_next, corner_b_next;

  logic                 out_valid, out_valid_next;
  logic signed [PW-1:0] out_x, out_y;
  logic [AW-1:0]        out_address;
  logic                 out_visible, out_last, emit_last;
  logic [COLOR_BITS-1:0] out_color;

  logic accept, emit;
  cmd_t command;

  // Endpoint selection for the line that is loaded this cycle.
  logic signed [CW-1:0] in_xs, in_ys, in_xe, in_ye, in_w, in_h;
  logic signed [CW-1:0] sel_l, sel_t, sel_r, sel_b;
  logic [1:0]           sel_seg;
  logic signed [CW-1:0] ld_x1, ld_y1, ld_x2, ld_y2;
  logic [CW-1:0]        ld_dx, ld_dy;
  logic signed [EW-1:0] ld_err;

  // Per-pixel arithmetic on the current position.
  logic                 at_target, vis;
  logic [AW-1:0]        px_a, py_a, sw_a, addr;
  logic signed [EW:0]   e2, dx_e, dy_e;
  logic                 move_x, move_y;

  assign command   = cmd_t'(cmd.command);
  assign cmd.ready = !out_valid || pix.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign in_xs = CW'(cmd.x_start);
  assign in_ys = CW'(cmd.y_start);
  assign in_xe = CW'(cmd.x_end);
  assign in_ye = CW'(cmd.y_end);
  assign in_w  = $signed(CW'(cmd.rect_width));
  assign in_h  = $signed(CW'(cmd.rect_height));

  always_comb begin
    if (command == CMD_RECT) begin
      sel_l   = in_xs;
      sel_t   = in_ys;
      sel_r   = in_xs + in_w - CW'(1);
      sel_b   = in_ys + in_h - CW'(1);
      sel_seg = 2'd0;
    end else begin
      sel_l   = corner_l;
      sel_t   = corner_t;
      sel_r   = corner_r;
      sel_b   = corner_b;
      sel_seg = segment_index + 2'd1;
    end
    case (sel_seg)
      2'd0: begin
        ld_x1 = sel_l; ld_y1 = sel_t; ld_x2 = sel_r; ld_y2 = sel_t;
      end
      2'd1: begin
        ld_x1 = sel_r; ld_y1 = sel_t; ld_x2 = sel_r; ld_y2 = sel_b;
      end
      2'd2: begin
        ld_x1 = sel_r; ld_y1 = sel_b; ld_x2 = sel_l; ld_y2 = sel_b;
      end
      default: begin
        ld_x1 = sel_l; ld_y1 = sel_b; ld_x2 = sel_l; ld_y2 = sel_t;
      end
    endcase
    if (command == CMD_LINE) begin
      ld_x1 = in_xs; ld_y1 = in_ys; ld_x2 = in_xe; ld_y2 = in_ye;
    end
    ld_dx  = (ld_x2 > ld_x1) ? $unsigned(ld_x2 - ld_x1) : $unsigned(ld_x1 - ld_x2);
    ld_dy  = (ld_y2 > ld_y1) ? $unsigned(ld_y2 - ld_y1) : $unsigned(ld_y1 - ld_y2);
    ld_err = $signed(EW'(ld_dx)) - $signed(EW'(ld_dy));
  end

  assign at_target = (cur_x == target_x) && (cur_y == target_y);
  assign vis = !cur_x[CW-1] && !cur_y[CW-1] &&
               ($unsigned(cur_x) < CW'(view_width)) &&
               ($unsigned(cur_y) < CW'(view_height));
  assign px_a = AW'($unsigned(cur_x));
  assign py_a = AW'($unsigned(cur_y));
  assign sw_a = AW'(view_width);
  assign addr = py_a * sw_a + px_a;

  assign e2     = {error_term, 1'b0};
  assign dx_e   = $signed(EW1'(delta_x));
  assign dy_e   = $signed(EW1'(delta_y));
  assign move_x = e2 > -dy_e;
  assign move_y = e2 < dx_e;

  always_comb begin
    active_next        = active;
    is_rectangle_next  = is_rectangle;
    segment_index_next = segment_index;
    cur_x_next         = cur_x;
    cur_y_next         = cur_y;
    target_x_next      = target_x;
    target_y_next      = target_y;
    delta_x_next       = delta_x;
    delta_y_next       = delta_y;
    step_x_neg_next    = step_x_neg;
    step_y_neg_next    = step_y_neg;
    error_term_next    = error_term;
    draw_color_next    = draw_color;
    corner_l_next      = corner_l;
    corner_t_next      = corner_t;
    corner_r_next      = corner_r;
    corner_b_next      = corner_b;
    emit               = 1'b0;
    emit_last          = 1'b0;
    if (accept) begin
      case (command)
        CMD_LINE, CMD_RECT: begin
          active_next        = 1'b1;
          is_rectangle_next  = (command == CMD_RECT);
          segment_index_next = 2'd0;
          draw_color_next    = cmd.color;
          corner_l_next      = sel_l;
          corner_t_next      = sel_t;
          corner_r_next      = sel_r;
          corner_b_next      = sel_b;
          cur_x_next         = ld_x1;
          cur_y_next         = ld_y1;
          target_x_next      = ld_x2;
          target_y_next      = ld_y2;
          delta_x_next       = ld_dx;
          delta_y_next       = ld_dy;
          step_x_neg_next    = !(ld_x1 < ld_x2);
          step_y_neg_next    = !(ld_y1 < ld_y2);
          error_term_next    = ld_err;
        end
        CMD_STEP: begin
          if (active) begin
            emit = 1'b1;
            if (at_target) begin
              if (is_rectangle && segment_index != 2'd3) begin
                segment_index_next = sel_seg;
                cur_x_next         = ld_x1;
                cur_y_next         = ld_y1;
                target_x_next      = ld_x2;
                target_y_next      = ld_y2;
                delta_x_next       = ld_dx;
                delta_y_next       = ld_dy;
                step_x_neg_next    = !(ld_x1 < ld_x2);
                step_y_neg_next    = !(ld_y1 < ld_y2);
                error_term_next    = ld_err;
              end else begin
                active_next = 1'b0;
                emit_last   = 1'b1;
              end
            end else begin
              error_term_next = error_term - (move_x ? $signed(EW'(delta_y)) : EW'(0))
                                           + (move_y ? $signed(EW'(delta_x)) : EW'(0));
              if (move_x) begin
                cur_x_next = step_x_neg ? cur_x - CW'(1) : cur_x + CW'(1);
              end
              if (move_y) begin
                cur_y_next = step_y_neg ? cur_y - CW'(1) : cur_y + CW'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    out_valid_next = emit || (out_valid && !pix.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width    <= VIEW_WIDTH_RESET;
      view_height   <= VIEW_HEIGHT_RESET;
      active        <= 1'b0;
      is_rectangle  <= 1'b0;
      segment_index <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == REG_VIEW_WIDTH) begin
        view_width <= cfg_data;
      end
      if (cfg_write && cfg_index == REG_VIEW_HEIGHT) begin
        view_height <= cfg_data;
      end
      active        <= active_next;
      is_rectangle  <= is_rectangle_next;
      segment_index <= segment_index_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_x      <= cur_x_next;
    cur_y      <= cur_y_next;
    target_x   <= target_x_next;
    target_y   <= target_y_next;
    delta_x    <= delta_x_next;
    delta_y    <= delta_y_next;
    step_x_neg <= step_x_neg_next;
    step_y_neg <= step_y_neg_next;
    error_term <= error_term_next;
    draw_color <= draw_color_next;
    corner_l   <= corner_l_next;
    corner_t   <= corner_t_next;
    corner_r   <= corner_r_next;
    corner_b   <= corner_b_next;
    if (emit) begin
      out_x       <= PW'(cur_x);
      out_y       <= PW'(cur_y);
      out_address <= vis ? addr : AW'(0);
      out_visible <= vis;
      out_color   <= draw_color;
      out_last    <= emit_last;
    end
  end

  assign pix.valid         = out_valid;
  assign pix.pixel_x       = out_x;
  assign pix.pixel_y       = out_y;
  assign pix.pixel_address = out_address;
  assign pix.visible       = out_visible;
  assign pix.pixel_color   = out_color;
  assign pix.last_pixel    = out_last;

`ifndef SYNTHESIS
  // A step request while drawing always leaves a pixel in the output register.
  assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_STEP && active |=> out_valid)
    else $error("step request while drawing gave no pixel");

  // A start request always leaves the drawer busy.
  assert property (@(posedge clk) disable iff (rst)
    accept && (command == CMD_LINE || command == CMD_RECT) |=> active)
    else $error("start request did not begin drawing");

  // Only a rectangle ever moves past its first segment.
  assert property (@(posedge clk) disable iff (rst)
    segment_index != 2'd0 |-> is_rectangle)
    else $error("segment advanced on a plain line");

  // Finishing the primitive marks the pixel as last and idles the walker.
  assert property (@(posedge clk) disable iff (rst)
    emit && emit_last |=> !active && out_last)
    else $error("final pixel not marked or drawer still busy");

  // A clipped pixel never carries an address.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_visible |-> out_address == AW'(0))
    else $error("clipped pixel with non-zero address");
`endif

endmodule

>>> tb/sv/clipped_line_rect_outline_drawer_tb.sv
// Self-checking testbench for the clipped line and rectangle outline pixel generator.
`timescale 1ns / 1ps

module clipped_line_rect_outline_drawer_tb;
  import cldr_pkg::*;

  localparam int COORD_BITS      = 12;
  localparam int SCREEN_DIM_BITS = 10;
  localparam int ADDR_BITS       = 2 * SCREEN_DIM_BITS;
  localparam int COORD_MIN       = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX       = (1 << (COORD_BITS - 1)) - 1;
  localparam int PHASE_ITEMS     = 215;
  localparam int SETTLE_CYCLES   = 8;
  localparam int QUIET_LIMIT     = 2000;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {SIDE_TOP, SIDE_RIGHT, SIDE_BOTTOM, SIDE_LEFT} side_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]          command;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
    logic [RECT_DIM_BITS-1:0]     rect_width;
    logic [RECT_DIM_BITS-1:0]     rect_height;
    logic [COLOR_BITS-1:0]        color;
  } draw_req_t;

  typedef struct packed {
    logic signed [COORD_BITS:0] x;
    logic signed [COORD_BITS:0] y;
    logic [ADDR_BITS-1:0]       addr;
    logic                       vis;
    logic [COLOR_BITS-1:0]      colour;
    logic                       last;
  } pixel_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [SCREEN_BITS-1:0]    cfg_data;

  cldr_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_ch ();
  cldr_pixel_if #(.COORD_BITS(COORD_BITS), .SCREEN_DIM_BITS(SCREEN_DIM_BITS)) pix_ch ();

  clipped_line_rect_outline_drawer #(
    .COORD_BITS     (COORD_BITS),
    .SCREEN_DIM_BITS(SCREEN_DIM_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd_ch),
    .pix      (pix_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Walker state of the drawer as the testbench sees it.
  int              scr_w = 320;
  int              scr_h = 240;
  bit              drawing;
  bit              outlining;
  side_t           side;
  int              pen_x, pen_y, goal_x, goal_y, run_x, run_y, err;
  bit              back_x, back_y;
  int              left, top, right, bottom;
  logic [COLOR_BITS-1:0] ink;

  draw_req_t draw_queue[$];
  pixel_t    pixels_due[$];
  draw_req_t cur_req;
  pixel_t    got, want;

  int requests_queued, requests_taken, stim_count;
  int pixels_seen, visible_seen, closing_seen, settings_used;
  int mismatches, quiet_cycles;
  int send_wait, recv_wait;
  bit send_calm, recv_calm;

  function automatic void aim(int x1, int y1, int x2, int y2);
    pen_x  = x1;
    pen_y  = y1;
    goal_x = x2;
    goal_y = y2;
    run_x  = x2 > x1 ? x2 - x1 : x1 - x2;
    run_y  = y2 > y1 ? y2 - y1 : y1 - y2;
    back_x = !(x1 < x2);
    back_y = !(y1 < y2);
    err    = run_x - run_y;
  endfunction

  function automatic void aim_side();
    case (side)
      SIDE_TOP:    aim(left, top, right, top);
      SIDE_RIGHT:  aim(right, top, right, bottom);
      SIDE_BOTTOM: aim(right, bottom, left, bottom);
      default:     aim(left, bottom, left, top);
    endcase
  endfunction

  // Applies one accepted request to the walker and records any pixel it yields.
  function automatic void trace_request(draw_req_t r);
    pixel_t p;
    int     e2;
    int     lin;
    if (r.command == CMD_LINE || r.command == CMD_RECT) begin
      ink       = r.color;
      drawing   = 1'b1;
      side      = SIDE_TOP;
      outlining = (r.command == CMD_RECT);
      if (outlining) begin
        left   = int'(r.x_start);
        top    = int'(r.y_start);
        right  = left + int'(r.rect_width) - 1;
        bottom = top + int'(r.rect_height) - 1;
        aim_side();
      end else begin
        aim(int'(r.x_start), int'(r.y_start), int'(r.x_end), int'(r.y_end));
      end
    end else if (r.command == CMD_STEP && drawing) begin
      lin      = pen_y * scr_w + pen_x;
      p.x      = pen_x[COORD_BITS:0];
      p.y      = pen_y[COORD_BITS:0];
      p.vis    = pen_x >= 0 && pen_y >= 0 && pen_x < scr_w && pen_y < scr_h;
      p.addr   = p.vis ? lin[ADDR_BITS-1:0] : '0;
      p.colour = ink;
      p.last   = 1'b0;
      if (pen_x == goal_x && pen_y == goal_y) begin
        if (outlining && side != SIDE_LEFT) begin
          side = side.next();
          aim_side();
        end else begin
          drawing = 1'b0;
          p.last  = 1'b1;
        end
      end else begin
        e2 = 2 * err;
        if (e2 > -run_y) begin
          err   -= run_y;
          pen_x += back_x ? -1 : 1;
        end
        if (e2 < run_x) begin
          err   += run_x;
          pen_y += back_y ? -1 : 1;
        end
      end
      pixels_due.push_back(p);
    end
  endfunction

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 49) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic draw_req_t random_req();
    logic [95:0] bits;
    draw_req_t   r;
    bits = {$urandom, $urandom, $urandom};
    r    = bits[$bits(draw_req_t)-1:0];
    return r;
  endfunction

  function automatic void post(draw_req_t r);
    draw_queue.push_back(r);
    requests_queued++;
    if (r.command != CMD_UNUSED) stim_count++;
  endfunction

  function automatic void post_start(logic [CMD_BITS-1:0] command, int xs, int ys, int xe,
                                     int ye, int w, int h, int colour);
    draw_req_t r;
    r             = random_req();
    r.command     = command;
    r.x_start     = xs[COORD_BITS-1:0];
    r.y_start     = ys[COORD_BITS-1:0];
    r.x_end       = xe[COORD_BITS-1:0];
    r.y_end       = ye[COORD_BITS-1:0];
    r.rect_width  = w[RECT_DIM_BITS-1:0];
    r.rect_height = h[RECT_DIM_BITS-1:0];
    r.color       = colour[COLOR_BITS-1:0];
    post(r);
  endfunction

  function automatic void post_steps(int n);
    draw_req_t r;
    repeat (n) begin
      r         = random_req();
      r.command = CMD_STEP;
      post(r);
    end
  endfunction

  // Usually finishes the primitive and idles a little; now and then cuts it short.
  function automatic void post_run(int pixels);
    if ($urandom_range(0, 6) == 0) post_steps($urandom_range(0, pixels));
    else post_steps(pixels + $urandom_range(0, 2));
  endfunction

  function automatic int clamp_coord(int v);
    return v < COORD_MIN ? COORD_MIN : (v > COORD_MAX ? COORD_MAX : v);
  endfunction

  function automatic int near_edge(int extent);
    return clamp_coord(int'($urandom_range(0, extent + 16)) - 8);
  endfunction

  function automatic int spread(int reach);
    return int'($urandom_range(0, 2 * reach)) - reach;
  endfunction

  function automatic int span(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic void queue_directed();
    draw_req_t r;
    r         = random_req();
    r.command = CMD_STEP;
    post(r);
    r.command = CMD_UNUSED;
    post(r);
    // Single-pixel line, then one step too many.
    post_start(CMD_LINE, 5, 5, 5, 5, 0, 0, 16'hFFFF);
    post_steps(2);
    // Rectangle hanging off the bottom-right corner of the screen.
    post_start(CMD_RECT, 319, 239, 0, 0, 2, 2, 16'h0000);
    post_steps(8);
    // Zero-sized rectangle, abandoned by a full-diagonal line, abandoned in turn.
    post_start(CMD_RECT, -1, -1, 0, 0, 0, 0, 16'h5A5A);
    post_steps(3);
    post_start(CMD_LINE, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, 16'hFFFF);
    post_steps(2);
    // Largest rectangle walks past the 12-bit coordinate range.
    post_start(CMD_RECT, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 2047, 2047, 16'hA5A5);
    post_steps(2);
  endfunction

  function automatic void queue_random(int budget);
    draw_req_t r;
    int        stop, pick, reach, xs, ys, xe, ye, w, h;
    stop = stim_count + budget;
    while (stim_count < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        reach = (pick < 47) ? 24 : 100;
        xs    = near_edge(scr_w);
        ys    = near_edge(scr_h);
        xe    = clamp_coord(xs + spread(reach));
        ye    = clamp_coord(ys + spread(reach));
        post_start(CMD_LINE, xs, ys, xe, ye, $urandom, $urandom, $urandom);
        post_run((span(xs, xe) > span(ys, ye) ? span(xs, xe) : span(ys, ye)) + 1);
      end else if (pick < 82) begin
        w = $urandom_range(0, 10);
        h = $urandom_range(0, 10);
        post_start(CMD_RECT, near_edge(scr_w), near_edge(scr_h), $urandom, $urandom, w, h,
                   $urandom);
        post_run(2 * ((w == 0 ? 2 : w) + (h == 0 ? 2 : h)));
      end else if (pick < 92) begin
        r         = random_req();
        r.command = $urandom_range(0, 1) ? CMD_RECT : CMD_LINE;
        post(r);
        post_steps($urandom_range(0, 6));
      end else if ($urandom_range(0, 1)) begin
        r         = random_req();
        r.command = CMD_UNUSED;
        post(r);
      end else begin
        post_steps($urandom_range(1, 3));
      end
    end
  endfunction

  task automatic settle();
    while (requests_taken != requests_queued || pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen(int w, int h);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_VIEW_WIDTH;
    cfg_data  <= w[SCREEN_BITS-1:0];
    @(posedge clk);
    scr_w = w;
    cfg_index <= REG_VIEW_HEIGHT;
    cfg_data  <= h[SCREEN_BITS-1:0];
    @(posedge clk);
    scr_h = h;
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Command driver: one request on the bus at a time, random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        trace_request(cur_req);
        requests_taken++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          cmd_ch.valid <= 1'b0;
        end else if (draw_queue.size() > 0) begin
          cur_req = draw_queue.pop_front();
          cmd_ch.command     <= cur_req.command;
          cmd_ch.x_start     <= cur_req.x_start;
          cmd_ch.y_start     <= cur_req.y_start;
          cmd_ch.x_end       <= cur_req.x_end;
          cmd_ch.y_end       <= cur_req.y_end;
          cmd_ch.rect_width  <= cur_req.rect_width;
          cmd_ch.rect_height <= cur_req.rect_height;
          cmd_ch.color       <= cur_req.color;
          cmd_ch.valid       <= 1'b1;
          send_wait = draw_gap(send_calm);
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        got.x      = pix_ch.pixel_x;
        got.y      = pix_ch.pixel_y;
        got.addr   = pix_ch.pixel_address;
        got.vis    = pix_ch.visible;
        got.colour = pix_ch.pixel_color;
        got.last   = pix_ch.last_pixel;
        if (pixels_due.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected pixel: x=%0d y=%0d addr=%0d vis=%0b colour=%h last=%0b",
                     got.x, got.y, got.addr, got.vis, got.colour, got.last);
          mismatches++;
        end else begin
          want = pixels_due.pop_front();
          pixels_seen++;
          visible_seen += want.vis;
          closing_seen += want.last;
          if (got.x !== want.x || got.y !== want.y || got.addr !== want.addr ||
              got.vis !== want.vis || got.colour !== want.colour || got.last !== want.last) begin
            if (mismatches < 10)
              $display({"Pixel mismatch: expected x=%0d y=%0d addr=%0d vis=%0b colour=%h ",
                        "last=%0b, got x=%0d y=%0d addr=%0d vis=%0b colour=%h last=%0b"},
                       want.x, want.y, want.addr, want.vis, want.colour, want.last,
                       got.x, got.y, got.addr, got.vis, got.colour, got.last);
            mismatches++;
          end
        end
        recv_wait = draw_gap(recv_calm);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      pix_ch.ready <= (recv_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready) || cfg_write)
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timed out with %0d pixels outstanding.", pixels_due.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int plan_w[7] = '{1, 1024, 0, 2047, 2047, 0, 64};
    int plan_h[7] = '{1, 1024, 0, 2047, 0, 2047, 48};
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = REG_VIEW_WIDTH;
    cfg_data           = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.command     = CMD_STEP;
    cmd_ch.x_start     = '0;
    cmd_ch.y_start     = '0;
    cmd_ch.x_end       = '0;
    cmd_ch.y_end       = '0;
    cmd_ch.rect_width  = '0;
    cmd_ch.rect_height = '0;
    cmd_ch.color       = '0;
    pix_ch.ready       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    queue_random(PHASE_ITEMS);
    for (int i = 0; i < 7; i++) begin
      settle();
      write_screen(plan_w[i], plan_h[i]);
      queue_random(PHASE_ITEMS);
    end
    settle();
    write_screen($urandom_range(1, 1024), $urandom_range(1, 1024));
    queue_random(PHASE_ITEMS);
    settle();

    $display("Sent %0d requests under %0d screen settings after reset.",
             requests_taken, settings_used);
    $display("Checked %0d pixels: %0d visible, %0d closing a primitive, %0d mismatched.",
             pixels_seen, visible_seen, closing_seen, mismatches);
    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> clipped_line_rect_outline_drawer.f
rtl/cldr_pkg.sv
rtl/cldr_if.sv
rtl/clipped_line_rect_outline_drawer.sv
tb/sv/clipped_line_rect_outline_drawer_tb.sv
